/* src/dtg_pkg.sv */
// constants, types and calendar helper functions for the day count to date block
// no dependencies
`timescale 1ns / 1ps

package dtg_pkg;

  localparam int DAY_COUNT_BITS = 24;
  localparam int DAYS_W = DAY_COUNT_BITS + 1;
  localparam int YEAR_W = DAY_COUNT_BITS;
  localparam int R400_W = 9;

  localparam int CFG_YEAR_W = 14;
  localparam int CFG_MONTH_W = 4;
  localparam int CFG_DAY_W = 5;

  localparam int OUT_YEAR_W = 16;
  localparam int OUT_MONTH_W = 4;
  localparam int OUT_DAY_W = 5;

  localparam int DAYS_PER_CYCLE = 146097;
  localparam int YEARS_PER_CYCLE = 400;
  localparam int YEAR_LIMIT = 65535;

  // reciprocal for the number of whole 400 year cycles in the day total
  localparam int QUOT_W = DAYS_W - 16;
  localparam int CYC_SHIFT = DAYS_W + 18;
  localparam int CYC_PROD_W = CYC_SHIFT + QUOT_W;
  localparam longint unsigned CYC_RECIP =
    ((64'd1 << CYC_SHIFT) + DAYS_PER_CYCLE - 1) / DAYS_PER_CYCLE;

  // reciprocal for the start year divided by 400
  localparam int YQ_W = CFG_YEAR_W - 8;
  localparam int Y_SHIFT = CFG_YEAR_W + 9;
  localparam int Y_PROD_W = Y_SHIFT + YQ_W;
  localparam int Y_RECIP = ((1 << Y_SHIFT) + YEARS_PER_CYCLE - 1) / YEARS_PER_CYCLE;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_START_YEAR = 2'd0;
  localparam logic [1:0] REG_START_MONTH = 2'd1;
  localparam logic [1:0] REG_START_DAY = 2'd2;

  localparam logic [CFG_YEAR_W-1:0] RST_START_YEAR = 14'd2000;
  localparam logic [CFG_MONTH_W-1:0] RST_START_MONTH = 4'd1;
  localparam logic [CFG_DAY_W-1:0] RST_START_DAY = 5'd1;

  typedef struct packed {
    logic [CFG_YEAR_W-1:0] year;
    logic [CFG_MONTH_W-1:0] month;
    logic [CFG_DAY_W-1:0] day;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic ymod;
    logic offs;
    logic divs;
    logic skip;
    logic ystep;
    logic mstep;
    logic oload;
  } dp_cmd_t;

  typedef struct packed {
    logic year_more;
    logic month_more;
  } dp_sts_t;

  // leap test from the year modulo 400
  function automatic logic leap400(input logic [R400_W-1:0] r);
    return (r != 9'd100) && (r != 9'd200) && (r != 9'd300) && (r[1:0] == 2'b00);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2: len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] month_base(input logic [3:0] m);
    logic [8:0] base;
    case (m)
      4'd2: base = 9'd31;
      4'd3: base = 9'd59;
      4'd4: base = 9'd90;
      4'd5: base = 9'd120;
      4'd6: base = 9'd151;
      4'd7: base = 9'd181;
      4'd8: base = 9'd212;
      4'd9: base = 9'd243;
      4'd10: base = 9'd273;
      4'd11: base = 9'd304;
      4'd12: base = 9'd334;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

/* src/dtg_ifs.sv */
// valid/ready channel interfaces for the day count input and the date output
// depends on dtg_pkg
`timescale 1ns / 1ps

interface dtg_in_if;
  logic valid;
  logic ready;
  logic [dtg_pkg::DAY_COUNT_BITS-1:0] day_count;
  modport source(output valid, output day_count, input ready);
  modport sink(input valid, input day_count, output ready);
endinterface

interface dtg_out_if;
  logic valid;
  logic ready;
  logic [dtg_pkg::OUT_YEAR_W-1:0] out_year;
  logic [dtg_pkg::OUT_MONTH_W-1:0] out_month;
  logic [dtg_pkg::OUT_DAY_W-1:0] out_day;
  modport source(output valid, output out_year, output out_month, output out_day,
                 input ready);
  modport sink(input valid, input out_year, input out_month, input out_day,
               output ready);
endinterface

/* src/dtg_regs.sv */
// apb configuration registers holding the start date
// depends on dtg_pkg
`timescale 1ns / 1ps

module dtg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtg_pkg::PADDR_W-1:0]   paddr,
  input  logic [dtg_pkg::PDATA_W-1:0]   pwdata,
  output logic [dtg_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output dtg_pkg::cfg_t                 cfg
);

  logic [1:0] reg_idx;
  logic wr_en;

  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.year <= dtg_pkg::RST_START_YEAR;
      cfg.month <= dtg_pkg::RST_START_MONTH;
      cfg.day <= dtg_pkg::RST_START_DAY;
    end else if (wr_en) begin
      case (reg_idx)
        dtg_pkg::REG_START_YEAR: cfg.year <= pwdata[dtg_pkg::CFG_YEAR_W-1:0];
        dtg_pkg::REG_START_MONTH: cfg.month <= pwdata[dtg_pkg::CFG_MONTH_W-1:0];
        dtg_pkg::REG_START_DAY: cfg.day <= pwdata[dtg_pkg::CFG_DAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dtg_pkg::REG_START_YEAR: prdata = dtg_pkg::PDATA_W'(cfg.year);
      dtg_pkg::REG_START_MONTH: prdata = dtg_pkg::PDATA_W'(cfg.month);
      dtg_pkg::REG_START_DAY: prdata = dtg_pkg::PDATA_W'(cfg.day);
      default: prdata = '0;
    endcase
  end

endmodule

/* src/dtg_dp.sv */
// datapath: reciprocal multiplies for the 400 year split, year and month stepping,
// result register; depends on dtg_pkg
`timescale 1ns / 1ps

module dtg_dp (
  input  logic                                   clk,
  input  dtg_pkg::dp_cmd_t                       cmd,
  input  dtg_pkg::cfg_t                          cfg,
  input  logic [dtg_pkg::DAY_COUNT_BITS-1:0]     day_count,
  output dtg_pkg::dp_sts_t                       sts,
  output logic [dtg_pkg::OUT_YEAR_W-1:0]         out_year,
  output logic [dtg_pkg::OUT_MONTH_W-1:0]        out_month,
  output logic [dtg_pkg::OUT_DAY_W-1:0]          out_day
);

  logic [dtg_pkg::DAYS_W-1:0] days;
  logic [dtg_pkg::YEAR_W-1:0] year;
  logic [dtg_pkg::QUOT_W-1:0] quot;
  logic [dtg_pkg::YQ_W-1:0] yq;
  logic [dtg_pkg::R400_W-1:0] r400;
  logic [3:0] month;

  logic [dtg_pkg::Y_PROD_W-1:0] y_prod;
  logic [dtg_pkg::CFG_YEAR_W-1:0] y_rem;
  logic [dtg_pkg::CYC_PROD_W-1:0] cyc_prod;

  logic [3:0] mc;
  logic [4:0] dc;
  logic [4:0] dim_s;
  logic leap_s;
  logic leap_r;
  logic [8:0] offset;
  logic [8:0] dy;
  logic [4:0] dm;

  // start year over 400 and whole 400 year cycles in the day total
  always_comb begin
    y_prod = dtg_pkg::Y_PROD_W'(cfg.year) * dtg_pkg::Y_PROD_W'(dtg_pkg::Y_RECIP);
    y_rem = year[dtg_pkg::CFG_YEAR_W-1:0]
            - dtg_pkg::CFG_YEAR_W'(yq) * dtg_pkg::CFG_YEAR_W'(dtg_pkg::YEARS_PER_CYCLE);
    cyc_prod = dtg_pkg::CYC_PROD_W'(days) * dtg_pkg::CYC_PROD_W'(dtg_pkg::CYC_RECIP);
  end

  // start date clamp and day offset within the start year
  always_comb begin
    if (cfg.month == 4'd0) begin
      mc = 4'd1;
    end else if (cfg.month > 4'd12) begin
      mc = 4'd12;
    end else begin
      mc = cfg.month;
    end
    leap_s = dtg_pkg::leap400(r400);
    dim_s = dtg_pkg::month_days(mc, leap_s);
    if (cfg.day == 5'd0) begin
      dc = 5'd1;
    end else if (cfg.day > dim_s) begin
      dc = dim_s;
    end else begin
      dc = cfg.day;
    end
    offset = dtg_pkg::month_base(mc) + {8'd0, leap_s && (mc > 4'd2)} + {4'd0, dc} - 9'd1;
  end

  always_comb begin
    leap_r = dtg_pkg::leap400(r400);
    dy = leap_r ? 9'd366 : 9'd365;
    dm = dtg_pkg::month_days(month, leap_r);
    sts.year_more = days >= dtg_pkg::DAYS_W'(dy);
    sts.month_more = (month < 4'd12) && (days >= dtg_pkg::DAYS_W'(dm));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      days <= {1'b0, day_count};
      year <= dtg_pkg::YEAR_W'(cfg.year);
      yq <= y_prod[dtg_pkg::Y_PROD_W-1:dtg_pkg::Y_SHIFT];
    end
    if (cmd.ymod) begin
      r400 <= y_rem[dtg_pkg::R400_W-1:0];
    end
    if (cmd.offs) begin
      days <= days + dtg_pkg::DAYS_W'(offset);
    end
    if (cmd.divs) begin
      quot <= cyc_prod[dtg_pkg::CYC_PROD_W-1:dtg_pkg::CYC_SHIFT];
    end
    if (cmd.skip) begin
      year <= year + dtg_pkg::YEAR_W'(quot) * dtg_pkg::YEAR_W'(dtg_pkg::YEARS_PER_CYCLE);
      days <= days - dtg_pkg::DAYS_W'(quot) * dtg_pkg::DAYS_W'(dtg_pkg::DAYS_PER_CYCLE);
      month <= 4'd1;
    end
    if (cmd.ystep) begin
      days <= days - dtg_pkg::DAYS_W'(dy);
      year <= year + 1'b1;
      r400 <= (r400 == dtg_pkg::R400_W'(dtg_pkg::YEARS_PER_CYCLE - 1)) ? '0 : r400 + 1'b1;
    end
    if (cmd.mstep) begin
      days <= days - dtg_pkg::DAYS_W'(dm);
      month <= month + 1'b1;
    end
    if (cmd.oload) begin
      if (year > dtg_pkg::YEAR_W'(dtg_pkg::YEAR_LIMIT)) begin
        out_year <= dtg_pkg::OUT_YEAR_W'(dtg_pkg::YEAR_LIMIT);
        out_month <= 4'd12;
        out_day <= 5'd31;
      end else begin
        out_year <= year[dtg_pkg::OUT_YEAR_W-1:0];
        out_month <= month;
        out_day <= days[dtg_pkg::OUT_DAY_W-1:0] + 1'b1;
      end
    end
  end

endmodule

/* src/dtg_ctrl.sv */
// controller state machine sequencing the datapath and the channel handshakes
// depends on dtg_pkg
`timescale 1ns / 1ps

module dtg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dtg_pkg::dp_sts_t  sts,
  output dtg_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_YMOD = 3'd1;
  localparam logic [2:0] S_OFFS = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_SKIP = 3'd4;
  localparam logic [2:0] S_YEAR = 3'd5;
  localparam logic [2:0] S_MON = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic out_valid_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_YMOD;
        end
      end
      S_YMOD: begin
        cmd.ymod = 1'b1;
        state_next = S_OFFS;
      end
      S_OFFS: begin
        cmd.offs = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.divs = 1'b1;
        state_next = S_SKIP;
      end
      S_SKIP: begin
        cmd.skip = 1'b1;
        state_next = S_YEAR;
      end
      S_YEAR: begin
        if (sts.year_more) begin
          cmd.ystep = 1'b1;
        end else begin
          state_next = S_MON;
        end
      end
      S_MON: begin
        if (sts.month_more) begin
          cmd.mstep = 1'b1;
        end else if (!out_valid || out_ready) begin
          cmd.oload = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.oload) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* src/day_count_to_gregorian_date.sv */
// top level: converts a day count into a gregorian date after a start date
// depends on dtg_pkg, dtg_ifs, dtg_regs, dtg_ctrl, dtg_dp
`timescale 1ns / 1ps
//
// din carries one day count per transaction; dout returns one date
// (year, month, day) per transaction, in order. the start date is to be set
// over the apb port only while the block is idle; the block itself does not
// enforce this. reset loads 2000-01-01. after acceptance a conversion takes
// one step each for the start year modulo 400, the offset in the start
// year, the reciprocal multiply that counts whole 400 year cycles and the
// cycle skip, then one step per remaining whole year (up to 399) plus one,
// and one per month (up to 11) plus one to load the result.
// one count is converted at a time; din is ready only while no
// conversion is running, so no new count is taken before the last one has
// finished. the result sits in an output register, so a new count is taken
// while dout stalls; a finished conversion waits for the register to free
// up. reset returns the controller to idle and drops dout.valid. years
// above 65535 saturate to 65535-12-31.
//

module day_count_to_gregorian_date (
  input  logic                          clk,
  input  logic                          rst,
  dtg_in_if.sink                        din,
  dtg_out_if.source                     dout,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtg_pkg::PADDR_W-1:0]   paddr,
  input  logic [dtg_pkg::PDATA_W-1:0]   pwdata,
  output logic [dtg_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  dtg_pkg::cfg_t cfg;
  dtg_pkg::dp_cmd_t cmd;
  dtg_pkg::dp_sts_t sts;

  dtg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dtg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtg_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .cfg       (cfg),
    .day_count (din.day_count),
    .sts       (sts),
    .out_year  (dout.out_year),
    .out_month (dout.out_month),
    .out_day   (dout.out_day)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready) |=> !din.ready)
    else $error("input accepted while a conversion is running");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (dout.out_month >= 4'd1 && dout.out_month <= 4'd12))
    else $error("result month out of range");

  a_day_nonzero: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (dout.out_day != 5'd0))
    else $error("result day is zero");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");
`endif

endmodule

/* test/day_count_to_gregorian_date_tb.sv */
// testbench for day_count_to_gregorian_date: drives day counts, predicts each date
// and checks every returned transaction in order; depends on dtg_pkg, dtg_ifs and the rtl
`timescale 1ns / 1ps

module day_count_to_gregorian_date_tb;
  import dtg_pkg::*;

  localparam int DAYS_CYCLE = 146097;
  localparam int HOLD_CYCLES = 3000;
  localparam int NUM_PHASES = 10;
  localparam int RANDOM_PER_PHASE = 93;
  localparam logic [DAY_COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [OUT_YEAR_W-1:0] year;
    logic [OUT_MONTH_W-1:0] month;
    logic [OUT_DAY_W-1:0] day;
  } civil_date_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic [DAY_COUNT_BITS-1:0] in_count = '0;
  logic out_ready = 1'b0;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  logic [CFG_YEAR_W-1:0] cfg_year = RST_START_YEAR;
  logic [CFG_MONTH_W-1:0] cfg_month = RST_START_MONTH;
  logic [CFG_DAY_W-1:0] cfg_day = RST_START_DAY;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_armed = 1'b0;
  int hold_count = 0;
  logic in_hold;

  int mismatches = 0;

  logic [DAY_COUNT_BITS-1:0] counts_pending[$];
  civil_date_t dates_expected[$];

  dtg_in_if din_ch();
  dtg_out_if dout_ch();

  assign din_ch.valid = in_valid;
  assign din_ch.day_count = in_count;
  assign dout_ch.ready = out_ready;

  day_count_to_gregorian_date DUT (
    .clk(clk),
    .rst(rst),
    .din(din_ch),
    .dout(dout_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  function automatic bit is_leap_year(input longint unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4) == 0;
  endfunction

  function automatic longint unsigned days_of_month(input longint unsigned y,
                                                    input longint unsigned m);
    case (m)
      2: return is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic longint unsigned days_of_year(input longint unsigned y);
    return is_leap_year(y) ? 366 : 365;
  endfunction

  // date that lies count days after the programmed start date
  function automatic civil_date_t civil_date(input logic [DAY_COUNT_BITS-1:0] count);
    longint unsigned y, m, d, dim, days, i;
    civil_date_t res;
    y = 64'(cfg_year);
    m = 64'(cfg_month);
    d = 64'(cfg_day);
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    dim = days_of_month(y, m);
    if (d < 1) d = 1;
    if (d > dim) d = dim;
    days = d - 1;
    for (i = 1; i < m; i++) days += days_of_month(y, i);
    days += 64'(count);
    y += (days / DAYS_CYCLE) * 400;
    days = days % DAYS_CYCLE;
    while (days >= days_of_year(y)) begin
      days -= days_of_year(y);
      y++;
    end
    m = 1;
    while (m < 12 && days >= days_of_month(y, m)) begin
      days -= days_of_month(y, m);
      m++;
    end
    d = days + 1;
    if (y > YEAR_LIMIT) begin
      y = YEAR_LIMIT;
      m = 12;
      d = 31;
    end
    res.year = y[OUT_YEAR_W-1:0];
    res.month = m[OUT_MONTH_W-1:0];
    res.day = d[OUT_DAY_W-1:0];
    return res;
  endfunction

  function automatic logic [DAY_COUNT_BITS-1:0] random_count();
    logic [DAY_COUNT_BITS-1:0] c;
    int unsigned k;
    case ($urandom_range(9))
      0, 1, 2, 3: c = DAY_COUNT_BITS'($urandom());
      4, 5: c = DAY_COUNT_BITS'($urandom_range(3000));
      6: c = COUNT_MAX - DAY_COUNT_BITS'($urandom_range(3000));
      7, 8: begin
        // around a 400 year boundary
        k = $urandom_range(1, 113);
        c = DAY_COUNT_BITS'(k * DAYS_CYCLE + $urandom_range(1500) - 750);
      end
      default: begin
        c = '0;
        c[$urandom_range(DAY_COUNT_BITS - 1)] = 1'b1;
        if ($urandom_range(1) != 0) c = ~c;
      end
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_START_YEAR: cfg_year = value[CFG_YEAR_W-1:0];
      REG_START_MONTH: cfg_month = value[CFG_MONTH_W-1:0];
      REG_START_DAY: cfg_day = value[CFG_DAY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_start_date(input int y, input int m, input int d);
    write_reg(REG_START_YEAR, PDATA_W'(y));
    write_reg(REG_START_MONTH, PDATA_W'(m));
    write_reg(REG_START_DAY, PDATA_W'(d));
  endtask

  task automatic wait_drained();
    while (counts_pending.size() != 0 || dates_expected.size() != 0) @(negedge clk);
  endtask

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst || !hold_armed) begin
      hold_count <= 0;
    end else if (hold_count != HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
    end
  end

  assign in_hold = hold_armed && hold_count != HOLD_CYCLES;

  // day count driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && din_ch.ready) begin
        dates_expected.push_back(civil_date(in_count));
        void'(counts_pending.pop_front());
      end
      if (in_valid && !din_ch.ready) begin
        in_valid <= 1'b1;
      end else if (counts_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_count <= counts_pending[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // date monitor
  always @(posedge clk) begin : watch_dates
    civil_date_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (dout_ch.valid && out_ready) begin
        if (dates_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected date %0d-%0d-%0d", dout_ch.out_year,
                                    dout_ch.out_month, dout_ch.out_day));
        end else begin
          want = dates_expected.pop_front();
          if (dout_ch.out_year !== want.year)
            report_mismatch($sformatf("year got %0d want %0d", dout_ch.out_year, want.year));
          if (dout_ch.out_month !== want.month)
            report_mismatch($sformatf("month got %0d want %0d", dout_ch.out_month,
                                      want.month));
          if (dout_ch.out_day !== want.day)
            report_mismatch($sformatf("day got %0d want %0d", dout_ch.out_day, want.day));
        end
      end
      out_ready <= !in_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #80_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    logic [DAY_COUNT_BITS-1:0] directed[$];
    int ph, i, y, m, d;
    directed = '{24'd0, 24'd1, 24'd30, 24'd31, 24'd59, 24'd60, 24'd365, 24'd366,
                 24'd1460, 24'd1461, 24'd36524, 24'd36525, 24'd36583, 24'd36584,
                 24'd146096, 24'd146097, 24'd146098, COUNT_MAX, 24'hAAAAAA,
                 24'h555555, 24'h800000, 24'h7FFFFF};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default start date, no idling
    foreach (directed[j]) counts_pending.push_back(directed[j]);
    wait_drained();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 47; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 47; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      case (ph)
        0: set_start_date(1, 1, 1);
        1: set_start_date(9999, 12, 31);
        2: set_start_date(2000, 2, 29);
        3: set_start_date(2100, 2, 28);
        4: set_start_date(1600, 12, 31);
        default: begin
          y = $urandom_range(1, 9999);
          m = $urandom_range(1, 12);
          d = $urandom_range(1, 32'(days_of_month(64'(y), 64'(m))));
          set_start_date(y, m, d);
        end
      endcase
      @(negedge clk);
      if (ph == 5) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_armed = 1'b1;
      end
      counts_pending.push_back('0);
      counts_pending.push_back(COUNT_MAX);
      for (i = 0; i < RANDOM_PER_PHASE; i++) counts_pending.push_back(random_count());
      wait_drained();
      hold_armed = 1'b0;
    end

    repeat (600) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
